### rtl/core/cfbx_pkg.sv
`timescale 1ns / 1ps

package cfbx_pkg;

  // Frame start marker
  localparam logic [7:0] START_BYTE = 8'h02;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Position within the bytes that one queued command produces
  typedef enum logic [2:0] {
    ST_START,
    ST_CMD,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_DATA,
    ST_SUM
  } cfbx_step_e;

  // One classified command for the back part
  typedef struct packed {
    logic        hdr;       // emit the four header bytes first
    logic [7:0]  cmd;
    logic [15:0] len;
    logic [7:0]  data;
    logic        has_data;  // emit one payload byte
    logic        has_cs;    // close the frame with the checksum
  } cfbx_op_t;

endpackage

### rtl/core/cfbx_front.sv
`timescale 1ns / 1ps

module cfbx_front import cfbx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  command_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        data_present_i,
  output logic        push_o,
  output cfbx_op_t    op_o
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] rem_q, rem_d;
  logic        len_zero;
  logic        take;

  assign len_zero = (payload_length_i == 16'd0);
  assign take     = data_present_i && (rem_q != 16'd0);

  // Classify the word and track how much payload is still due
  always_comb begin
    in_frame_d = in_frame_q;
    rem_d      = rem_q;
    push_o     = 1'b0;
    op_o       = '0;
    op_o.cmd   = command_i;
    op_o.len   = payload_length_i;
    op_o.data  = data_byte_i;
    if (accept_i) begin
      if (!in_frame_q) begin
        push_o        = 1'b1;
        op_o.hdr      = 1'b1;
        op_o.has_data = !len_zero && data_present_i;
        op_o.has_cs   = len_zero || (data_present_i && (payload_length_i == 16'd1));
        rem_d         = len_zero ? 16'd0
                                 : payload_length_i - {15'd0, data_present_i};
        in_frame_d    = !len_zero && !op_o.has_cs;
      end else if (take) begin
        push_o        = 1'b1;
        op_o.has_data = 1'b1;
        op_o.has_cs   = (rem_q == 16'd1);
        rem_d         = rem_q - 16'd1;
        in_frame_d    = (rem_q != 16'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      rem_q      <= 16'd0;
    end else begin
      in_frame_q <= in_frame_d;
      rem_q      <= rem_d;
    end
  end

endmodule

### rtl/core/cfbx_queue.sv
`timescale 1ns / 1ps

module cfbx_queue import cfbx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cfbx_op_t push_op_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output cfbx_op_t head_op_o
);

  cfbx_op_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o       = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_op_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Count follows pushes and pops
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_op_i;
  end

endmodule

### rtl/core/cfbx_back.sv
`timescale 1ns / 1ps

module cfbx_back import cfbx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cfbx_op_t   head_op_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_end_o
);

  cfbx_step_e step_q, step_d, cur_step, next_step;
  logic       busy_q, busy_d;
  logic [7:0] xor_q, xor_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_end_q, out_end_d;
  logic       load;
  logic       last;
  logic [7:0] cur_byte;

  assign load     = head_valid_i && (!out_valid_q || out_ready_i);
  assign cur_step = busy_q ? step_q : (head_op_i.hdr ? ST_START : ST_DATA);

  // Select the byte and the following step
  always_comb begin
    cur_byte  = 8'd0;
    next_step = ST_START;
    last      = 1'b0;
    unique case (cur_step)
      ST_START: begin
        cur_byte  = START_BYTE;
        next_step = ST_CMD;
      end
      ST_CMD: begin
        cur_byte  = head_op_i.cmd;
        next_step = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        cur_byte  = head_op_i.len[7:0];
        next_step = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        cur_byte  = head_op_i.len[15:8];
        if (head_op_i.has_data) begin
          next_step = ST_DATA;
        end else if (head_op_i.has_cs) begin
          next_step = ST_SUM;
        end else begin
          last = 1'b1;
        end
      end
      ST_DATA: begin
        cur_byte = head_op_i.data;
        if (head_op_i.has_cs) begin
          next_step = ST_SUM;
        end else begin
          last = 1'b1;
        end
      end
      ST_SUM: begin
        cur_byte = xor_q;
        last     = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign pop_o = load && last;

  // Advance the sequence, fold the checksum and fill the output word
  always_comb begin
    step_d      = step_q;
    busy_d      = busy_q;
    xor_d       = xor_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    if (load) begin
      step_d      = next_step;
      busy_d      = !last;
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_end_d   = (cur_step == ST_SUM);
      case (cur_step)
        ST_START: xor_d = START_BYTE;
        ST_SUM:   xor_d = 8'd0;
        default:  xor_d = xor_q ^ cur_byte;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_START;
      busy_q      <= 1'b0;
      xor_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_end_o   = out_end_q;

endmodule

### rtl/core/command_frame_builder_xor.sv
`timescale 1ns / 1ps
// The first byte a word causes passes through the command queue and then the output register.
// Output: one byte per cycle, set by the back sequencer, while commands wait and m_axis_tready
// holds high; a payload word yields one or two bytes (two when it closes the frame), a header four to six.
// A four-entry command queue lets input words keep flowing while a header drains.
// Reset (rst_ni low, asynchronous) empties the queue and output and awaits a header.
module command_frame_builder_xor import cfbx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [7:0] command, [23:8] payload_length, [31:24] data_byte
  input  logic        s_axis_tuser,   // [0] data_present
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast    // frame_end
);

  logic     full;
  logic     push;
  cfbx_op_t push_op;
  logic     head_valid;
  cfbx_op_t head_op;
  logic     pop;

  assign s_axis_tready = !full;

  cfbx_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (s_axis_tvalid && !full),
    .command_i        (s_axis_tdata[7:0]),
    .payload_length_i (s_axis_tdata[23:8]),
    .data_byte_i      (s_axis_tdata[31:24]),
    .data_present_i   (s_axis_tuser),
    .push_o           (push),
    .op_o             (push_op)
  );

  cfbx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_op_i    (push_op),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_op_o    (head_op)
  );

  cfbx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_op_i    (head_op),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_end_o    (m_axis_tlast)
  );

endmodule
